// ----- hdl/pdtc_pkg.sv -----
// shared constants, types and register codes for the programmable delay timer controller
// no dependencies; used by pdtc_hms and programmable_delay_timer_controller
`timescale 1ns / 1ps
`default_nettype none

package pdtc_pkg;

  // width of elapsed and setpoint counts in seconds
  localparam int TIME_WIDTH = 17;

  localparam int HOURS_WIDTH   = 5;
  localparam int MINUTES_WIDTH = 6;
  localparam int SECS_WIDTH    = 6;

  localparam int SEC_DIV_WIDTH    = 10;
  localparam int REF_DIV_WIDTH    = 8;
  localparam int LONG_PRESS_WIDTH = 3;

  // configuration port: data is as wide as the widest register (max_setpoint)
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = TIME_WIDTH;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_SECOND_DIVISOR     = 2'd0,
    REG_REFRESH_DIVISOR    = 2'd1,
    REG_LONG_PRESS_SECONDS = 2'd2,
    REG_MAX_SETPOINT       = 2'd3
  } cfg_reg_t;

  localparam logic [SEC_DIV_WIDTH-1:0]    SECOND_DIVISOR_RST     = SEC_DIV_WIDTH'(490);
  localparam logic [REF_DIV_WIDTH-1:0]    REFRESH_DIVISOR_RST    = REF_DIV_WIDTH'(30);
  localparam logic [LONG_PRESS_WIDTH-1:0] LONG_PRESS_SECONDS_RST = LONG_PRESS_WIDTH'(2);
  localparam logic [TIME_WIDTH-1:0]       MAX_SETPOINT_RST       = TIME_WIDTH'(86399);

  // reciprocal constants for exact division of a TIME_WIDTH value by 60 and 3600:
  // the shift covers log2 of the divisor so the rounding error never reaches one
  localparam int MIN_SHIFT  = TIME_WIDTH + 6;
  localparam int HOUR_SHIFT = TIME_WIDTH + 12;
  localparam int PROD_WIDTH = HOUR_SHIFT + TIME_WIDTH;

  localparam logic [63:0] MIN_RECIP_FULL  = ((64'd1 << MIN_SHIFT) + 64'd59) / 64'd60;
  localparam logic [63:0] HOUR_RECIP_FULL = ((64'd1 << HOUR_SHIFT) + 64'd3599) / 64'd3600;

  localparam logic [TIME_WIDTH:0] MIN_RECIP  = MIN_RECIP_FULL[TIME_WIDTH:0];
  localparam logic [TIME_WIDTH:0] HOUR_RECIP = HOUR_RECIP_FULL[TIME_WIDTH:0];

  // load enables of the two conversion stages
  typedef struct packed {
    logic load_split;
    logic load_out;
  } pipe_ctrl_t;

endpackage

`default_nettype wire

// ----- hdl/pdtc_hms.sv -----
// two-stage conversion of a count of seconds into hours, minutes and seconds
// depends on pdtc_pkg
`timescale 1ns / 1ps
`default_nettype none

module pdtc_hms (
  input  logic                               clk,
  input  pdtc_pkg::pipe_ctrl_t               ctrl,
  input  logic [pdtc_pkg::TIME_WIDTH-1:0]    value,
  output logic [pdtc_pkg::HOURS_WIDTH-1:0]   hours,
  output logic [pdtc_pkg::MINUTES_WIDTH-1:0] minutes,
  output logic [pdtc_pkg::SECS_WIDTH-1:0]    secs
);
  import pdtc_pkg::*;

  logic [PROD_WIDTH-1:0] min_prod;
  logic [PROD_WIDTH-1:0] hour_prod;
  logic [TIME_WIDTH-1:0] value_q;
  logic [TIME_WIDTH-1:0] min_total;
  logic [TIME_WIDTH-1:0] hour_total;
  logic [TIME_WIDTH-1:0] min_x60;
  logic [TIME_WIDTH-1:0] hour_x60;
  logic [TIME_WIDTH-1:0] sec_rem;
  logic [TIME_WIDTH-1:0] min_rem;

  // value / 60 and value / 3600 by reciprocal multiply
  assign min_prod  = PROD_WIDTH'(value) * PROD_WIDTH'(MIN_RECIP);
  assign hour_prod = PROD_WIDTH'(value) * PROD_WIDTH'(HOUR_RECIP);

  // remainders stay below 60, so wrapping arithmetic is exact
  assign min_x60  = (min_total << 6) - (min_total << 2);
  assign hour_x60 = (hour_total << 6) - (hour_total << 2);
  assign sec_rem  = value_q - min_x60;
  assign min_rem  = min_total - hour_x60;

  always_ff @(posedge clk) begin
    if (ctrl.load_split) begin
      value_q    <= value;
      min_total  <= min_prod[MIN_SHIFT +: TIME_WIDTH];
      hour_total <= hour_prod[HOUR_SHIFT +: TIME_WIDTH];
    end
    if (ctrl.load_out) begin
      hours   <= hour_total[HOURS_WIDTH-1:0];
      minutes <= min_rem[MINUTES_WIDTH-1:0];
      secs    <= sec_rem[SECS_WIDTH-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/programmable_delay_timer_controller.sv -----
// programmable on-delay timer relay controller: tick dividers, encoder, button, timing
// throughput: one item per cycle while the result channel is not stalled; three
//   register stages (state update, reciprocal multiply, remainder subtract), each
//   loads whenever the stage after it has room
// reset (rst, synchronous): registers back to defaults, all state and valid bits clear
// depends on pdtc_pkg and pdtc_hms
`timescale 1ns / 1ps
`default_nettype none

module programmable_delay_timer_controller (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration write port
  input  logic                                 cfg_write,
  input  logic [pdtc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [pdtc_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  // item channel
  input  logic                                 item_valid,
  output logic                                 item_stall,
  input  logic                                 tick,
  input  logic                                 encoder_clk,
  input  logic                                 encoder_dt,
  input  logic                                 button_level,
  // result channel
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic                                 load_on,
  output logic                                 running,
  output logic                                 setup_mode,
  output logic                                 refresh,
  output logic [pdtc_pkg::TIME_WIDTH-1:0]      elapsed_total,
  output logic [pdtc_pkg::TIME_WIDTH-1:0]      setpoint_total,
  output logic [pdtc_pkg::HOURS_WIDTH-1:0]     elapsed_hours,
  output logic [pdtc_pkg::MINUTES_WIDTH-1:0]   elapsed_minutes,
  output logic [pdtc_pkg::SECS_WIDTH-1:0]      elapsed_secs,
  output logic [pdtc_pkg::HOURS_WIDTH-1:0]     set_hours,
  output logic [pdtc_pkg::MINUTES_WIDTH-1:0]   set_minutes,
  output logic [pdtc_pkg::SECS_WIDTH-1:0]      set_secs
);
  import pdtc_pkg::*;

  // per-beat status carried down the pipeline
  typedef struct packed {
    logic                  load;
    logic                  run;
    logic                  mode;
    logic                  refresh;
    logic [TIME_WIDTH-1:0] elapsed;
    logic [TIME_WIDTH-1:0] setpoint;
  } status_t;

  // configuration registers
  logic [SEC_DIV_WIDTH-1:0]    second_divisor;
  logic [REF_DIV_WIDTH-1:0]    refresh_divisor;
  logic [LONG_PRESS_WIDTH-1:0] long_press_seconds;
  logic [TIME_WIDTH-1:0]       max_setpoint;

  // controller state
  logic [SEC_DIV_WIDTH-1:0]    second_tick_count, second_tick_count_next;
  logic [REF_DIV_WIDTH-1:0]    refresh_tick_count, refresh_tick_count_next;
  logic                        second_pending, second_pending_next;
  logic                        press_second_pending, press_second_pending_next;
  logic                        refresh_pending, refresh_pending_next;
  logic                        encoder_armed, encoder_armed_next;
  logic [LONG_PRESS_WIDTH-1:0] held_seconds, held_seconds_next;
  logic                        short_press_flag, short_press_flag_next;
  logic                        long_press_flag, long_press_flag_next;
  logic                        run_flag, run_flag_next;
  logic                        mode_flag, mode_flag_next;
  logic                        load_flag, load_flag_next;
  logic [TIME_WIDTH-1:0]       elapsed_count, elapsed_count_next;
  logic [TIME_WIDTH-1:0]       setpoint_value, setpoint_value_next;

  // combinational helpers of the state update
  logic [SEC_DIV_WIDTH-1:0] sec_count_inc;
  logic [REF_DIV_WIDTH-1:0] ref_count_inc;
  logic                     enc_up;
  logic                     enc_down;
  logic                     short_event;
  logic                     refresh_out;
  status_t                  status_next;

  // pipeline stages
  logic       s1_valid;
  status_t    s1;
  logic       s2_valid;
  status_t    s2;
  pipe_ctrl_t pipe_ctrl;
  logic       take;
  logic       accept;

  // ---------------------------------------------------------------------------
  // handshake: every stage moves when the one after it has room, so a waiting
  // result still leaves the earlier stages free to fill
  // ---------------------------------------------------------------------------
  assign pipe_ctrl.load_out   = !result_valid || !result_stall;
  assign pipe_ctrl.load_split = !s2_valid || pipe_ctrl.load_out;
  assign take                 = !s1_valid || pipe_ctrl.load_split;
  assign item_stall           = !take;
  assign accept               = item_valid && take;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      second_divisor     <= SECOND_DIVISOR_RST;
      refresh_divisor    <= REFRESH_DIVISOR_RST;
      long_press_seconds <= LONG_PRESS_SECONDS_RST;
      max_setpoint       <= MAX_SETPOINT_RST;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_SECOND_DIVISOR:     second_divisor     <= cfg_data[SEC_DIV_WIDTH-1:0];
        REG_REFRESH_DIVISOR:    refresh_divisor    <= cfg_data[REF_DIV_WIDTH-1:0];
        REG_LONG_PRESS_SECONDS: long_press_seconds <= cfg_data[LONG_PRESS_WIDTH-1:0];
        REG_MAX_SETPOINT:       max_setpoint       <= cfg_data[TIME_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // one control pass per item: dividers, encoder, button, timing and setpoint
  // ---------------------------------------------------------------------------
  always_comb begin
    sec_count_inc = second_tick_count + 1'b1;
    ref_count_inc = refresh_tick_count + 1'b1;

    second_tick_count_next    = second_tick_count;
    refresh_tick_count_next   = refresh_tick_count;
    second_pending_next       = second_pending;
    press_second_pending_next = press_second_pending;
    refresh_pending_next      = refresh_pending;
    encoder_armed_next        = encoder_armed;
    held_seconds_next         = held_seconds;
    short_press_flag_next     = short_press_flag;
    long_press_flag_next      = long_press_flag;
    run_flag_next             = run_flag;
    mode_flag_next            = mode_flag;
    load_flag_next            = load_flag;
    elapsed_count_next        = elapsed_count;
    setpoint_value_next       = setpoint_value;
    enc_up                    = 1'b0;
    enc_down                  = 1'b0;
    short_event               = 1'b0;

    // tick dividers; a counter that wraps to zero also fires, and divisor 0 acts as 1
    if (tick) begin
      if (sec_count_inc >= second_divisor || sec_count_inc == '0) begin
        second_tick_count_next    = '0;
        second_pending_next       = 1'b1;
        press_second_pending_next = 1'b1;
      end else begin
        second_tick_count_next = sec_count_inc;
      end
      if (ref_count_inc >= refresh_divisor || ref_count_inc == '0) begin
        refresh_tick_count_next = '0;
        refresh_pending_next    = 1'b1;
      end else begin
        refresh_tick_count_next = ref_count_inc;
      end
    end

    // encoder: clock low steps up, data low while disarmed steps down
    if (!encoder_clk) begin
      encoder_armed_next = 1'b1;
      enc_up             = 1'b1;
    end else if (!encoder_dt && !encoder_armed) begin
      encoder_armed_next = 1'b1;
      enc_down           = 1'b1;
    end
    if (encoder_clk && encoder_dt) begin
      encoder_armed_next = 1'b0;
    end

    // push button, active low
    if (!button_level) begin
      if (press_second_pending_next) begin
        if (held_seconds != '1) begin
          held_seconds_next = held_seconds + 1'b1;
        end
        press_second_pending_next = 1'b0;
      end
      if (held_seconds_next > long_press_seconds) begin
        long_press_flag_next = 1'b1;
      end else begin
        short_press_flag_next = 1'b1;
      end
    end else begin
      // release: a long press may also have set the short flag early in its hold
      if (short_press_flag) begin
        short_event           = 1'b1;
        short_press_flag_next = 1'b0;
        held_seconds_next     = '0;
      end
      if (long_press_flag) begin
        run_flag_next        = !run_flag;
        long_press_flag_next = 1'b0;
        held_seconds_next    = '0;
      end
    end
    if (short_event) begin
      mode_flag_next = !mode_flag;
    end

    if (run_flag_next) begin
      // a second left pending while idle is counted at once after start
      if (second_pending_next) begin
        if (elapsed_count != '1) begin
          elapsed_count_next = elapsed_count + 1'b1;
        end
        second_pending_next = 1'b0;
        load_flag_next      = elapsed_count_next <= setpoint_value;
        run_flag_next       = load_flag_next;
      end
    end else begin
      elapsed_count_next = '0;
      if (enc_up && setpoint_value < max_setpoint && setpoint_value != '1) begin
        setpoint_value_next = setpoint_value + 1'b1;
      end
      if (enc_down && setpoint_value != '0) begin
        setpoint_value_next = setpoint_value - 1'b1;
      end
    end

    // refresh is reported once and then dropped
    refresh_out          = refresh_pending_next;
    refresh_pending_next = 1'b0;

    status_next.load     = load_flag_next;
    status_next.run      = run_flag_next;
    status_next.mode     = mode_flag_next;
    status_next.refresh  = refresh_out;
    status_next.elapsed  = elapsed_count_next;
    status_next.setpoint = setpoint_value_next;
  end

  // ---------------------------------------------------------------------------
  // state and valid bits
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      second_tick_count    <= '0;
      refresh_tick_count   <= '0;
      second_pending       <= 1'b0;
      press_second_pending <= 1'b0;
      refresh_pending      <= 1'b0;
      encoder_armed        <= 1'b0;
      held_seconds         <= '0;
      short_press_flag     <= 1'b0;
      long_press_flag      <= 1'b0;
      run_flag             <= 1'b0;
      mode_flag            <= 1'b0;
      load_flag            <= 1'b0;
      elapsed_count        <= '0;
      setpoint_value       <= '0;
      s1_valid             <= 1'b0;
      s2_valid             <= 1'b0;
      result_valid         <= 1'b0;
    end else begin
      if (accept) begin
        second_tick_count    <= second_tick_count_next;
        refresh_tick_count   <= refresh_tick_count_next;
        second_pending       <= second_pending_next;
        press_second_pending <= press_second_pending_next;
        refresh_pending      <= refresh_pending_next;
        encoder_armed        <= encoder_armed_next;
        held_seconds         <= held_seconds_next;
        short_press_flag     <= short_press_flag_next;
        long_press_flag      <= long_press_flag_next;
        run_flag             <= run_flag_next;
        mode_flag            <= mode_flag_next;
        load_flag            <= load_flag_next;
        elapsed_count        <= elapsed_count_next;
        setpoint_value       <= setpoint_value_next;
      end
      if (take) begin
        s1_valid <= accept;
      end
      if (pipe_ctrl.load_split) begin
        s2_valid <= s1_valid;
      end
      if (pipe_ctrl.load_out) begin
        result_valid <= s2_valid;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (take) begin
      s1 <= status_next;
    end
    if (pipe_ctrl.load_split) begin
      s2 <= s1;
    end
    if (pipe_ctrl.load_out) begin
      load_on        <= s2.load;
      running        <= s2.run;
      setup_mode     <= s2.mode;
      refresh        <= s2.refresh;
      elapsed_total  <= s2.elapsed;
      setpoint_total <= s2.setpoint;
    end
  end

  // hours, minutes and seconds follow the totals through stages two and three
  pdtc_hms u_elapsed_hms (
    .clk     (clk),
    .ctrl    (pipe_ctrl),
    .value   (s1.elapsed),
    .hours   (elapsed_hours),
    .minutes (elapsed_minutes),
    .secs    (elapsed_secs)
  );

  pdtc_hms u_setpoint_hms (
    .clk     (clk),
    .ctrl    (pipe_ctrl),
    .value   (s1.setpoint),
    .hours   (set_hours),
    .minutes (set_minutes),
    .secs    (set_secs)
  );

endmodule

`default_nettype wire

// ----- verif/programmable_delay_timer_controller_tb.sv -----
// self-checking bench for programmable_delay_timer_controller: a cycle-free model of
// the divider, encoder, button and delay logic predicts every result beat
// depends on pdtc_pkg and the controller rtl
`timescale 1ns / 1ps

module programmable_delay_timer_controller_tb;
  import pdtc_pkg::*;

  // one expected result beat
  typedef struct {
    logic                     load_on;
    logic                     running;
    logic                     setup_mode;
    logic                     refresh;
    logic [TIME_WIDTH-1:0]    elapsed_total;
    logic [TIME_WIDTH-1:0]    setpoint_total;
    logic [HOURS_WIDTH-1:0]   elapsed_hours;
    logic [MINUTES_WIDTH-1:0] elapsed_minutes;
    logic [SECS_WIDTH-1:0]    elapsed_secs;
    logic [HOURS_WIDTH-1:0]   set_hours;
    logic [MINUTES_WIDTH-1:0] set_minutes;
    logic [SECS_WIDTH-1:0]    set_secs;
  } timer_readout_t;

  // dut ports, every input known from time zero
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = REG_SECOND_DIVISOR;
  logic [CFG_DATA_WIDTH-1:0] cfg_data = '0;
  logic item_valid = 1'b0;
  logic item_stall;
  logic tick = 1'b0;
  logic encoder_clk = 1'b1;
  logic encoder_dt = 1'b1;
  logic button_level = 1'b1;
  logic result_valid;
  logic result_stall = 1'b0;
  logic load_on, running, setup_mode, refresh;
  logic [TIME_WIDTH-1:0] elapsed_total, setpoint_total;
  logic [HOURS_WIDTH-1:0] elapsed_hours, set_hours;
  logic [MINUTES_WIDTH-1:0] elapsed_minutes, set_minutes;
  logic [SECS_WIDTH-1:0] elapsed_secs, set_secs;

  programmable_delay_timer_controller uut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .item_valid(item_valid), .item_stall(item_stall),
    .tick(tick), .encoder_clk(encoder_clk), .encoder_dt(encoder_dt),
    .button_level(button_level),
    .result_valid(result_valid), .result_stall(result_stall),
    .load_on(load_on), .running(running), .setup_mode(setup_mode), .refresh(refresh),
    .elapsed_total(elapsed_total), .setpoint_total(setpoint_total),
    .elapsed_hours(elapsed_hours), .elapsed_minutes(elapsed_minutes),
    .elapsed_secs(elapsed_secs), .set_hours(set_hours), .set_minutes(set_minutes),
    .set_secs(set_secs)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor copy of the registers, at their reset values
  logic [SEC_DIV_WIDTH-1:0]    sec_div_cfg      = SECOND_DIVISOR_RST;
  logic [REF_DIV_WIDTH-1:0]    refresh_div_cfg  = REFRESH_DIVISOR_RST;
  logic [LONG_PRESS_WIDTH-1:0] long_press_cfg   = LONG_PRESS_SECONDS_RST;
  logic [TIME_WIDTH-1:0]       setpoint_ceiling = MAX_SETPOINT_RST;

  // predictor copy of the controller state, all clear after reset
  logic [SEC_DIV_WIDTH-1:0] sec_ticks = '0;
  logic [REF_DIV_WIDTH-1:0] refresh_ticks = '0;
  logic [2:0] held_secs = '0;
  logic [TIME_WIDTH-1:0] elapsed_count = '0;
  logic [TIME_WIDTH-1:0] setpoint_count = '0;
  bit sec_due, press_sec_due, refresh_due, enc_armed;
  bit short_hold, long_hold, run_active, mode_active, load_active;

  timer_readout_t pending_readouts[$];

  // stimulus shaping knobs, set per test
  int tick_pct = 50;
  int gap_max = 4;
  int burst_left = 0;

  // bookkeeping for the summary
  int mismatch_count = 0;
  int items_sent = 0;
  int results_seen = 0;
  int reg_writes = 0;
  int runs_started = 0;
  int runs_completed = 0;
  int mode_flips = 0;

  // receiver stall pattern state
  int stall_cycle = 0;
  int stall_kind = 0;

  // hours, minutes and seconds of a count, packed as {h, m, s}
  function automatic logic [HOURS_WIDTH+MINUTES_WIDTH+SECS_WIDTH-1:0] to_hms(
      input logic [TIME_WIDTH-1:0] value);
    int unsigned v;
    v = 32'(value);
    return {HOURS_WIDTH'(v / 3600), MINUTES_WIDTH'((v % 3600) / 60), SECS_WIDTH'(v % 60)};
  endfunction

  // one loop pass of the controller: dividers, encoder, button, timing, readout
  function automatic timer_readout_t advance_timer(input logic t, input logic ec,
                                                   input logic ed, input logic btn);
    timer_readout_t r;
    logic [SEC_DIV_WIDTH-1:0] sec_next;
    logic [REF_DIV_WIDTH-1:0] refresh_next;
    bit inc, dec, flip_mode;
    inc = 1'b0;
    dec = 1'b0;
    flip_mode = 1'b0;

    // dividers: reaching or passing the divisor fires, so a zero divisor acts like one
    if (t) begin
      sec_next = sec_ticks + 1'b1;
      if (sec_next >= sec_div_cfg || sec_next == '0) begin
        sec_ticks = '0;
        sec_due = 1'b1;
        press_sec_due = 1'b1;
      end else begin
        sec_ticks = sec_next;
      end
      refresh_next = refresh_ticks + 1'b1;
      if (refresh_next >= refresh_div_cfg || refresh_next == '0) begin
        refresh_ticks = '0;
        refresh_due = 1'b1;
      end else begin
        refresh_ticks = refresh_next;
      end
    end

    // encoder: clk low steps up every pass, dt low steps down once until both pins rest
    if (!ec) begin
      enc_armed = 1'b1;
      inc = 1'b1;
    end else if (!ed && !enc_armed) begin
      enc_armed = 1'b1;
      dec = 1'b1;
    end
    if (ec && ed) enc_armed = 1'b0;

    // button: held seconds decide short or long, release acts on the flags
    if (!btn) begin
      if (press_sec_due) begin
        if (held_secs != 3'd7) held_secs = held_secs + 1'b1;
        press_sec_due = 1'b0;
      end
      if (held_secs > long_press_cfg) long_hold = 1'b1;
      else short_hold = 1'b1;
    end else begin
      if (short_hold) begin
        flip_mode = 1'b1;
        short_hold = 1'b0;
        held_secs = '0;
      end
      if (long_hold) begin
        run_active = !run_active;
        if (run_active) runs_started++;
        long_hold = 1'b0;
        held_secs = '0;
      end
    end
    if (flip_mode) begin
      mode_active = !mode_active;
      mode_flips++;
    end

    // timing while running, setpoint edits while idle
    if (run_active) begin
      if (sec_due) begin
        if (elapsed_count != '1) elapsed_count = elapsed_count + 1'b1;
        sec_due = 1'b0;
        load_active = elapsed_count <= setpoint_count;
        run_active = load_active;
        if (!run_active) runs_completed++;
      end
    end else begin
      elapsed_count = '0;
      if (inc && setpoint_count < setpoint_ceiling && setpoint_count != '1)
        setpoint_count = setpoint_count + 1'b1;
      if (dec && setpoint_count != '0) setpoint_count = setpoint_count - 1'b1;
    end

    r.refresh = refresh_due;
    refresh_due = 1'b0;
    r.load_on = load_active;
    r.running = run_active;
    r.setup_mode = mode_active;
    r.elapsed_total = elapsed_count;
    r.setpoint_total = setpoint_count;
    {r.elapsed_hours, r.elapsed_minutes, r.elapsed_secs} = to_hms(elapsed_count);
    {r.set_hours, r.set_minutes, r.set_secs} = to_hms(setpoint_count);
    return r;
  endfunction

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", field, want, got);
      mismatch_count++;
    end
  endfunction

  // result side: compare each accepted beat with the oldest prediction, then pick
  // the next stall value from a randomly chosen stall pattern
  always @(posedge clk) begin : result_sink
    timer_readout_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_readouts.size() == 0) begin
        $error("result beat arrived with no item beat outstanding");
        mismatch_count++;
      end else begin
        want = pending_readouts.pop_front();
        results_seen++;
        check_field("load_on", 32'(want.load_on), 32'(load_on));
        check_field("running", 32'(want.running), 32'(running));
        check_field("setup_mode", 32'(want.setup_mode), 32'(setup_mode));
        check_field("refresh", 32'(want.refresh), 32'(refresh));
        check_field("elapsed_total", 32'(want.elapsed_total), 32'(elapsed_total));
        check_field("setpoint_total", 32'(want.setpoint_total), 32'(setpoint_total));
        check_field("elapsed_hours", 32'(want.elapsed_hours), 32'(elapsed_hours));
        check_field("elapsed_minutes", 32'(want.elapsed_minutes), 32'(elapsed_minutes));
        check_field("elapsed_secs", 32'(want.elapsed_secs), 32'(elapsed_secs));
        check_field("set_hours", 32'(want.set_hours), 32'(set_hours));
        check_field("set_minutes", 32'(want.set_minutes), 32'(set_minutes));
        check_field("set_secs", 32'(want.set_secs), 32'(set_secs));
      end
    end
    stall_cycle = stall_cycle + 1;
    if (stall_cycle % 48 == 0) stall_kind = $urandom_range(0, 3);
    case (stall_kind)
      0: result_stall <= 1'b0;                           // free-running stretch
      1: result_stall <= stall_cycle[0];                 // alternating stalls
      2: result_stall <= ($urandom_range(0, 99) < 40);   // scattered stalls
      default: result_stall <= (stall_cycle % 8) < 5;    // long stall runs
    endcase
  end

  function automatic logic roll_tick();
    return $urandom_range(0, 99) < tick_pct;
  endfunction

  // send one pass; valid stays high across back-to-back beats and drops only for a gap
  task automatic send_pass(input logic t, input logic ec, input logic ed, input logic btn);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gap_max == 0 || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, gap_max);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    item_valid <= 1'b1;
    tick <= t;
    encoder_clk <= ec;
    encoder_dt <= ed;
    button_level <= btn;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    // beat accepted at this edge
    pending_readouts.push_back(advance_timer(t, ec, ed, btn));
    items_sent++;
  endtask

  // let every outstanding result drain, then let the pipeline empty
  task automatic wait_for_idle();
    item_valid <= 1'b0;
    while (pending_readouts.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // one register write; junk above the register width must be ignored
  task automatic write_reg(input cfg_reg_t idx, input int unsigned value, input int width);
    logic [CFG_DATA_WIDTH-1:0] data;
    data = CFG_DATA_WIDTH'(($urandom << width) | value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_SECOND_DIVISOR:     sec_div_cfg = data[SEC_DIV_WIDTH-1:0];
      REG_REFRESH_DIVISOR:    refresh_div_cfg = data[REF_DIV_WIDTH-1:0];
      REG_LONG_PRESS_SECONDS: long_press_cfg = data[LONG_PRESS_WIDTH-1:0];
      default:                setpoint_ceiling = data[TIME_WIDTH-1:0];
    endcase
    reg_writes++;
  endtask

  // only called with the block idle
  task automatic program_timer(input int unsigned sec_div, input int unsigned ref_div,
                               input int unsigned long_secs, input int unsigned ceiling);
    write_reg(REG_SECOND_DIVISOR, sec_div, SEC_DIV_WIDTH);
    write_reg(REG_REFRESH_DIVISOR, ref_div, REF_DIV_WIDTH);
    write_reg(REG_LONG_PRESS_SECONDS, long_secs, LONG_PRESS_WIDTH);
    write_reg(REG_MAX_SETPOINT, ceiling, TIME_WIDTH);
    cfg_write <= 1'b0;
  endtask

  // random setting, mostly fast dividers so that presses and runs complete
  task automatic program_random();
    int unsigned sec_div, ref_div, ceiling;
    case ($urandom_range(0, 9))
      0: sec_div = 1023;
      1: sec_div = 0;
      default: sec_div = $urandom_range(1, 4);
    endcase
    ref_div = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 8);
    case ($urandom_range(0, 3))
      0: ceiling = 86399;
      1: ceiling = $urandom_range(1, 86399);
      default: ceiling = $urandom_range(1, 20);
    endcase
    program_timer(sec_div, ref_div, $urandom_range(0, 6), ceiling);
  endtask

  task automatic idle_passes(input int n);
    repeat (n) send_pass(roll_tick(), 1'b1, 1'b1, 1'b1);
  endtask

  task automatic noise_passes(input int n);
    repeat (n) send_pass(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  // detents of the encoder; up holds clk low (one step per pass), down pulses dt low
  task automatic turn_encoder(input bit up, input int detents);
    repeat (detents) begin
      repeat ($urandom_range(1, 3)) begin
        if (up) send_pass(roll_tick(), 1'b0, 1'($urandom_range(0, 1)), 1'b1);
        else send_pass(roll_tick(), 1'b1, 1'b0, 1'b1);
      end
      send_pass(roll_tick(), 1'b1, 1'b1, 1'b1);
    end
  endtask

  task automatic press_button(input int passes);
    repeat (passes) send_pass(roll_tick(), 1'b1, 1'b1, 1'b0);
    send_pass(roll_tick(), 1'b1, 1'b1, 1'b1);
  endtask

  // hold until the hold counts as long, bounded for slow dividers, then release
  task automatic long_press();
    int n;
    n = 0;
    while (!long_hold && n < 100) begin
      send_pass(roll_tick(), 1'b1, 1'b1, 1'b0);
      n++;
    end
    send_pass(roll_tick(), 1'b1, 1'b1, 1'b1);
  endtask

  // toggle running, let it time out or cut it short with a second long press
  task automatic run_delay(input int wait_limit, input bit stop_early);
    int n;
    long_press();
    n = 0;
    while (run_active && n < wait_limit) begin
      send_pass(roll_tick(), 1'b1, 1'b1, 1'b1);
      n++;
    end
    if (stop_early && run_active) long_press();
  endtask

  // ---------------------------------------------------------------- tests

  // hand-written passes under fast settings, each comment gives the expected effect
  task automatic test_directed_corners();
    gap_max = 2;
    send_pass(1'b0, 1'b1, 1'b1, 1'b1);  // reset defaults, nothing happens
    send_pass(1'b1, 1'b0, 1'b0, 1'b0);  // every pin active at once under defaults
    send_pass(1'b0, 1'b1, 1'b1, 1'b1);  // release
    wait_for_idle();
    program_timer(1, 1, 1, 2);
    send_pass(1'b1, 1'b0, 1'b1, 1'b1);  // tick fires both pulses, setpoint up
    send_pass(1'b0, 1'b0, 1'b0, 1'b1);  // clk held low again, but the ceiling stops the step
    send_pass(1'b0, 1'b0, 1'b1, 1'b1);  // already at the ceiling, stays
    send_pass(1'b0, 1'b1, 1'b1, 1'b1);  // pins at rest disarm
    send_pass(1'b0, 1'b1, 1'b0, 1'b1);  // dt low steps down once
    send_pass(1'b0, 1'b1, 1'b0, 1'b1);  // dt still low, armed, no step
    send_pass(1'b0, 1'b1, 1'b1, 1'b1);  // disarm
    send_pass(1'b0, 1'b1, 1'b1, 1'b0);  // press eats the old second, still short
    send_pass(1'b0, 1'b1, 1'b1, 1'b1);  // short release flips setup mode
    send_pass(1'b0, 1'b1, 1'b1, 1'b0);  // press, short so far
    send_pass(1'b1, 1'b1, 1'b1, 1'b0);  // one held second, still short
    send_pass(1'b1, 1'b1, 1'b1, 1'b0);  // two held seconds, now long
    send_pass(1'b0, 1'b1, 1'b1, 1'b1);  // release: mode flips, run starts, due second counts
    send_pass(1'b0, 1'b1, 1'b1, 1'b1);  // no tick, elapsed holds
    send_pass(1'b1, 1'b1, 1'b1, 1'b1);  // elapsed passes setpoint, load and run drop
    send_pass(1'b1, 1'b0, 1'b1, 1'b1);  // idle again, elapsed clears, setpoint up
    send_pass(1'b1, 1'b1, 1'b1, 1'b0);  // held seconds with ticks
    send_pass(1'b1, 1'b1, 1'b1, 1'b0);  // long
    send_pass(1'b1, 1'b1, 1'b1, 1'b1);  // start with a second already due
    send_pass(1'b1, 1'b0, 1'b0, 1'b0);  // encoder ignored while running, press held
  endtask

  // setpoint steps, saturation at zero and at the ceiling, ceiling below the setpoint
  task automatic test_encoder_limits();
    wait_for_idle();
    program_timer($urandom_range(1, 8), $urandom_range(1, 40), $urandom_range(0, 6), 3);
    tick_pct = 40;
    gap_max = 3;
    repeat (20) turn_encoder(1'($urandom_range(0, 1)), $urandom_range(1, 4));
    wait_for_idle();
    program_timer($urandom_range(1, 8), $urandom_range(1, 40), $urandom_range(0, 6), 12);
    repeat (6) turn_encoder(1'b1, 3);
    // ceiling dropped under the setpoint: steps up are ignored, steps down still act
    wait_for_idle();
    program_timer($urandom_range(1, 8), $urandom_range(1, 40), $urandom_range(0, 6), 1);
    repeat (8) turn_encoder(1'($urandom_range(0, 1)), $urandom_range(1, 3));
  endtask

  // short and long presses of random length, held seconds saturating at seven
  task automatic test_button_presses();
    wait_for_idle();
    program_timer($urandom_range(1, 3), $urandom_range(1, 255), $urandom_range(0, 6), 86399);
    tick_pct = 60;
    gap_max = 5;
    repeat (20) begin
      press_button($urandom_range(1, 12));
      idle_passes($urandom_range(0, 3));
    end
    wait_for_idle();
    program_timer(1, $urandom_range(1, 255), 6, 86399);
    tick_pct = 100;
    gap_max = 0;
    press_button(12);
    press_button(12);
  endtask

  // set a delay, start it and let it run out or stop it by a long press
  task automatic test_delay_runs();
    int unsigned ceiling;
    repeat (6) begin
      wait_for_idle();
      case ($urandom_range(0, 2))
        0: ceiling = 86399;
        1: ceiling = $urandom_range(1, 86399);
        default: ceiling = $urandom_range(1, 20);
      endcase
      program_timer($urandom_range(1, 3), $urandom_range(1, 255), $urandom_range(0, 2),
                    ceiling);
      tick_pct = $urandom_range(60, 100);
      gap_max = $urandom_range(0, 6);
      turn_encoder(1'($urandom_range(0, 1)), $urandom_range(1, 6));
      turn_encoder(1'b1, $urandom_range(1, 6));
      run_delay(40, $urandom_range(0, 2) == 0);
    end
  endtask

  // widest divisors, then zero divisors that fire on every tick
  task automatic test_divider_extremes();
    wait_for_idle();
    program_timer(1023, 255, 6, 86399);
    tick_pct = 100;
    gap_max = 2;
    idle_passes(260);
    // the counters are far past these divisors, so the first tick fires
    wait_for_idle();
    program_timer(0, 0, 0, 86399);
    noise_passes(20);
    run_delay(10, 1'b1);
  endtask

  // random settings and a random mix of every kind of sequence plus line noise
  task automatic test_mixed_traffic();
    while (items_sent < 1300) begin
      wait_for_idle();
      program_random();
      tick_pct = $urandom_range(20, 100);
      gap_max = $urandom_range(0, 6);
      repeat ($urandom_range(6, 12)) begin
        case ($urandom_range(0, 5))
          0: noise_passes($urandom_range(3, 20));
          1: turn_encoder(1'($urandom_range(0, 1)), $urandom_range(1, 5));
          2: press_button($urandom_range(1, 4));
          3: run_delay(50, 1'($urandom_range(0, 1)));
          4: idle_passes($urandom_range(1, 10));
          default: press_button($urandom_range(5, 30));
        endcase
      end
    end
  endtask

  // main sequence
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed_corners();
    test_encoder_limits();
    test_button_presses();
    test_delay_runs();
    test_divider_extremes();
    test_mixed_traffic();
    wait_for_idle();
    $display("covered %0d item beats, %0d result beats checked, %0d register writes",
             items_sent, results_seen, reg_writes);
    $display("timed runs started %0d, run to the end %0d, setup mode flips %0d",
             runs_started, runs_completed, mode_flips);
    if (mismatch_count == 0) begin
      $display("PASS programmable_delay_timer_controller");
    end else begin
      $display("FAIL programmable_delay_timer_controller");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("FAIL programmable_delay_timer_controller");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/pdtc_pkg.sv
hdl/pdtc_hms.sv
hdl/programmable_delay_timer_controller.sv
verif/programmable_delay_timer_controller_tb.sv
